// ===== hdl/rom_image_header_loader_assert.svh =====
// ============================================================================
// ROM image header loader assertion macros
// Shared concurrent assertion shorthands for the loader's modules.
// ============================================================================
`ifndef ROM_IMAGE_HEADER_LOADER_ASSERT_SVH
`define ROM_IMAGE_HEADER_LOADER_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define RIL_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define RIL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define RIL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/ril_pkg.sv =====
// ============================================================================
// ROM image loader package
// Request types, command format and status codes shared by the loader.
// ============================================================================
package ril_pkg;

    // One incoming image byte request.
    typedef struct packed {
        logic [7:0] image_byte;
        logic       first;
    } t_in_item;

    // One result request.
    typedef struct packed {
        logic        is_write;
        logic [15:0] address;
        logic [7:0]  data;
        logic [2:0]  status;
        logic        last;
    } t_out_item;

    // Status codes.
    localparam logic [2:0] STATUS_BUSY         = 3'd0;
    localparam logic [2:0] STATUS_LOADED       = 3'd1;
    localparam logic [2:0] STATUS_BAD_MARKS    = 3'd2;
    localparam logic [2:0] STATUS_BAD_VERSION  = 3'd3;
    localparam logic [2:0] STATUS_BAD_CHECKSUM = 3'd4;

    // Command kinds passed from the front end to the back end.
    typedef enum logic {
        CMD_SINGLE,
        CMD_VECTORS
    } t_cmd_kind;

    // A single command carries a finished result; a vector command carries the
    // selected vector pairs, which the back end expands into a write burst.
    typedef struct packed {
        t_cmd_kind       kind;
        t_out_item       single;
        logic [2:0]      vec_mask;
        logic [5:0][7:0] vec_bytes;
        logic            size_zero;
    } t_cmd;

endpackage

// ===== hdl/rom_image_header_loader.sv =====
// ============================================================================
// ROM image header loader
// Checks a ROM image header and turns the image into memory write requests.
// ============================================================================
// Usage: image bytes enter through a queue-style port: a request is taken when
// push is high and full is low; first marks the first header byte and restarts
// loading at any time. Results leave through a queue-style port: the oldest
// result is on o_result while empty is low and is taken when pop is high.
// Header bytes 0 to 14 give no result; byte 15 gives one error status, the
// selected vector writes (up to six), or, with no vectors and no payload, the
// loaded status. Each payload byte gives one write, the final one carrying the
// loaded status. Bytes after completion are dropped. A vector burst is loaded
// into the back end, then gives one write per cycle while the receiver takes them.
// Throughput: one byte per cycle while full is low; the command queue absorbs
// the time that a header with vectors holds the back end.
// Reset (synchronous, active low) clears the phase, counters and queues; no
// clearing pass is run. When the receiver stalls, the output register holds its
// result, the command queue fills, and full rises after QUEUE_DEPTH commands.
// ============================================================================
module rom_image_header_loader #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  ril_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output ril_pkg::t_out_item o_result
);

    logic          accept;
    logic          cmd_valid;
    ril_pkg::t_cmd cmd;
    logic          head_valid;
    ril_pkg::t_cmd head;
    logic          head_pop;

    assign accept = push && !full;

    // Header capture and classification, payload tracking and command issue.
    ril_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    // Commands waiting for the back end.
    ril_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (cmd_valid),
        .i_cmd        (cmd),
        .o_full       (full),
        .i_pop        (head_pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    // Write generation and output register.
    ril_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_head_pop   (head_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_result     (o_result)
    );

endmodule

// ===== hdl/ril_front.sv =====
// ============================================================================
// ROM image loader front end
// Captures and checks the header, tracks the payload and issues commands.
// ============================================================================
`include "rom_image_header_loader_assert.svh"

module ril_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  ril_pkg::t_in_item i_item,
    output logic              o_cmd_valid,
    output ril_pkg::t_cmd     o_cmd
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PAYLOAD,
        PH_DONE
    } t_phase;

    localparam logic [7:0] START_MARK    = 8'h5A;
    localparam logic [7:0] END_MARK      = 8'hA5;
    localparam logic [7:0] MAJOR_VERSION = 8'h01;
    localparam logic [3:0] SUM_FIRST     = 4'd3;
    localparam logic [3:0] SUM_LAST      = 4'd13;
    localparam logic [3:0] HEADER_END    = 4'd15;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_index, n_index;
    logic [7:0]  r_sum, n_sum;
    logic [15:0] r_load_ptr, n_load_ptr;
    logic [15:0] r_bytes_left, n_bytes_left;
    logic [7:0]  r_store [16];

    t_phase      eff_phase;
    logic [3:0]  eff_index;
    logic [7:0]  eff_sum;
    logic [7:0]  in_byte;
    logic [15:0] hdr_size;
    logic [15:0] left_dec;

    assign in_byte  = i_item.image_byte;
    assign hdr_size = {r_store[6], r_store[5]};
    assign left_dec = 16'(r_bytes_left - 16'd1);

    // A first byte restarts the header capture in the same cycle.
    always_comb begin
        if (i_item.first) begin
            eff_phase = PH_HEADER;
            eff_index = '0;
            eff_sum   = '0;
        end else begin
            eff_phase = r_phase;
            eff_index = r_index;
            eff_sum   = r_sum;
        end
    end

    // Next state and command generation.
    always_comb begin
        n_phase      = r_phase;
        n_index      = r_index;
        n_sum        = r_sum;
        n_load_ptr   = r_load_ptr;
        n_bytes_left = r_bytes_left;
        o_cmd_valid  = 1'b0;
        o_cmd        = '0;
        o_cmd.kind   = ril_pkg::CMD_SINGLE;
        if (i_accept) begin
            n_phase = eff_phase;
            n_index = eff_index;
            n_sum   = eff_sum;
            case (eff_phase)
                PH_HEADER: begin
                    if (eff_index >= SUM_FIRST && eff_index <= SUM_LAST) begin
                        n_sum = 8'(eff_sum + in_byte);
                    end
                    if (eff_index == HEADER_END) begin
                        n_phase                = PH_DONE;
                        o_cmd.single.last      = 1'b1;
                        if (r_store[0] != START_MARK || in_byte != END_MARK) begin
                            o_cmd_valid         = 1'b1;
                            o_cmd.single.status = ril_pkg::STATUS_BAD_MARKS;
                        end else if (r_store[2] != MAJOR_VERSION) begin
                            o_cmd_valid         = 1'b1;
                            o_cmd.single.status = ril_pkg::STATUS_BAD_VERSION;
                        end else if (eff_sum != r_store[14]) begin
                            o_cmd_valid         = 1'b1;
                            o_cmd.single.status = ril_pkg::STATUS_BAD_CHECKSUM;
                        end else begin
                            n_load_ptr   = {r_store[4], r_store[3]};
                            n_bytes_left = hdr_size;
                            if (hdr_size != 16'd0) begin
                                n_phase = PH_PAYLOAD;
                            end
                            if (r_store[7][2:0] != 3'd0) begin
                                o_cmd_valid     = 1'b1;
                                o_cmd.kind      = ril_pkg::CMD_VECTORS;
                                o_cmd.vec_mask  = r_store[7][2:0];
                                o_cmd.vec_bytes = {r_store[13], r_store[12], r_store[11],
                                                   r_store[10], r_store[9], r_store[8]};
                                o_cmd.size_zero = (hdr_size == 16'd0);
                            end else if (hdr_size == 16'd0) begin
                                o_cmd_valid         = 1'b1;
                                o_cmd.single.status = ril_pkg::STATUS_LOADED;
                            end
                        end
                    end else begin
                        n_index = 4'(eff_index + 4'd1);
                    end
                end
                PH_PAYLOAD: begin
                    o_cmd_valid           = 1'b1;
                    o_cmd.single.is_write = 1'b1;
                    o_cmd.single.address  = r_load_ptr;
                    o_cmd.single.data     = in_byte;
                    o_cmd.single.last     = 1'b1;
                    o_cmd.single.status   = (left_dec == 16'd0) ? ril_pkg::STATUS_LOADED
                                                                : ril_pkg::STATUS_BUSY;
                    n_bytes_left          = left_dec;
                    n_load_ptr            = 16'(r_load_ptr + 16'd1);
                    if (left_dec == 16'd0) begin
                        n_phase = PH_DONE;
                    end
                end
                default: begin
                    // Stray bytes while idle or finished are dropped.
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_index      <= '0;
            r_sum        <= '0;
            r_load_ptr   <= '0;
            r_bytes_left <= '0;
        end else begin
            r_phase      <= n_phase;
            r_index      <= n_index;
            r_sum        <= n_sum;
            r_load_ptr   <= n_load_ptr;
            r_bytes_left <= n_bytes_left;
        end
    end

    // Header byte capture.
    always_ff @(posedge i_clk) begin
        if (i_accept && eff_phase == PH_HEADER) begin
            r_store[eff_index] <= in_byte;
        end
    end

    `RIL_ASSERT_ALWAYS(a_payload_has_bytes, i_clk, i_rst_n, (r_phase != PH_PAYLOAD) || (r_bytes_left != 16'd0), "payload phase with no bytes left")

endmodule

// ===== hdl/ril_cmd_queue.sv =====
// ============================================================================
// ROM image loader command queue
// Short first-in first-out queue between the front end and the back end.
// ============================================================================
`include "rom_image_header_loader_assert.svh"

module ril_cmd_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ril_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_head_valid,
    output ril_pkg::t_cmd o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ril_pkg::t_cmd r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_wr_ptr + 1'b1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_rd_ptr + 1'b1);
        end
        if (do_push && !do_pop) begin
            n_count = CNT_W'(r_count + 1'b1);
        end else if (do_pop && !do_push) begin
            n_count = CNT_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    `RIL_ASSERT_ALWAYS(a_count_in_range, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "queue count beyond depth")
    `RIL_ASSERT_IMPLY(a_no_push_when_full, i_clk, i_rst_n, o_full, !i_push, "command pushed into a full queue")

endmodule

// ===== hdl/ril_back.sv =====
// ============================================================================
// ROM image loader back end
// Expands commands into result requests and holds the output register.
// ============================================================================
`include "rom_image_header_loader_assert.svh"

module ril_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_head_valid,
    input  ril_pkg::t_cmd      i_head,
    output logic               o_head_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output ril_pkg::t_out_item o_result
);

    localparam logic [15:0] VECTOR_BASE = 16'hFFFA;

    logic                  r_busy;
    logic [2:0]            r_mask;
    logic                  r_hi;
    logic [5:0][7:0]       r_vec;
    logic                  r_size_zero;
    logic                  r_out_valid;
    ril_pkg::t_out_item    r_out;

    logic                  advance;
    logic [1:0]            pair;
    logic [2:0]            pair_bit;
    logic [2:0]            rest_mask;
    logic                  beat_last;
    ril_pkg::t_out_item    beat;

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;
    assign advance  = !r_out_valid || i_pop;

    // Lowest selected vector pair still to be written.
    always_comb begin
        if (r_mask[0]) begin
            pair = 2'd0;
        end else if (r_mask[1]) begin
            pair = 2'd1;
        end else begin
            pair = 2'd2;
        end
        pair_bit  = 3'(3'b001 << pair);
        rest_mask = r_mask & ~pair_bit;
        beat_last = r_hi && (rest_mask == 3'd0);
    end

    // One vector write of the burst.
    always_comb begin
        beat.is_write = 1'b1;
        beat.address  = 16'(VECTOR_BASE + {13'd0, pair, r_hi});
        beat.data     = r_vec[{pair, r_hi}];
        beat.status   = (beat_last && r_size_zero) ? ril_pkg::STATUS_LOADED
                                                   : ril_pkg::STATUS_BUSY;
        beat.last     = beat_last;
    end

    // A single command leaves the queue only when the output can take it.
    assign o_head_pop = !r_busy && i_head_valid
                        && (i_head.kind == ril_pkg::CMD_VECTORS || advance);

    // Burst sequencing and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_hi        <= 1'b0;
            r_mask      <= '0;
        end else if (r_busy) begin
            if (advance) begin
                r_out       <= beat;
                r_out_valid <= 1'b1;
                if (r_hi) begin
                    r_hi   <= 1'b0;
                    r_mask <= rest_mask;
                    if (rest_mask == 3'd0) begin
                        r_busy <= 1'b0;
                    end
                end else begin
                    r_hi <= 1'b1;
                end
            end
        end else if (i_head_valid && i_head.kind == ril_pkg::CMD_VECTORS) begin
            r_busy      <= 1'b1;
            r_mask      <= i_head.vec_mask;
            r_hi        <= 1'b0;
            r_vec       <= i_head.vec_bytes;
            r_size_zero <= i_head.size_zero;
            if (advance) begin
                r_out_valid <= 1'b0;
            end
        end else if (i_head_valid && advance) begin
            r_out       <= i_head.single;
            r_out_valid <= 1'b1;
        end else if (advance) begin
            r_out_valid <= 1'b0;
        end
    end

    `RIL_ASSERT_IMPLY(a_busy_has_pairs, i_clk, i_rst_n, r_busy, r_mask != 3'd0, "vector burst with no pair selected")
    `RIL_ASSERT_NEXT(a_burst_holds, i_clk, i_rst_n, r_busy && !advance, $stable(r_mask) && $stable(r_hi), "vector burst moved while stalled")

endmodule
